[design/dtg_pkg.sv]
// display timing generator package
// holds the timing constants, the phase and register index codes, and the state, config and
// result structs shared by the step logic and the top level; depends on nothing

package dtg_pkg;

  localparam int unsigned AccW = 11;
  localparam int unsigned LineW = 8;

  localparam logic [AccW-1:0] DRAW_CYCLES = 11'd960;
  localparam logic [AccW-1:0] BLANK_CYCLES = 11'd272;
  localparam logic [LineW-1:0] FIRST_VBLANK_LINE = 8'd160;
  localparam logic [LineW-1:0] LAST_LINE = 8'd227;

  typedef enum logic [1:0] {
    PH_DRAW   = 2'd0,
    PH_BLANK  = 2'd1,
    PH_VDRAW  = 2'd2,
    PH_VBLANK = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    REG_MATCH_LINE = 2'd0,
    REG_HBLANK_IE  = 2'd1,
    REG_VBLANK_IE  = 2'd2,
    REG_MATCH_IE   = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [LineW-1:0] match_line;
    logic             hblank_ie;
    logic             vblank_ie;
    logic             match_ie;
  } dtg_cfg_t;

  typedef struct packed {
    logic [AccW-1:0]  acc;
    phase_e           phase;
    logic [LineW-1:0] line;
    logic             hblank;
    logic             vblank;
    logic             match;
  } dtg_state_t;

  typedef struct packed {
    logic [LineW-1:0] line;
    logic [1:0]       phase;
    logic             hblank_flag;
    logic             vblank_flag;
    logic             match_flag;
    logic             hblank_irq;
    logic             vblank_irq;
    logic             match_irq;
    logic             render_strobe;
    logic             dma_hblank_strobe;
    logic             dma_vblank_strobe;
  } dtg_result_t;

endpackage

[design/dtg_in_if.sv]
// input channel of the display timing generator
// carries valid, ready and the elapsed-cycle count; no dependencies

interface dtg_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] elapsed;

  modport source (output valid, output elapsed, input ready);
  modport sink (input valid, input elapsed, output ready);
endinterface

[design/dtg_out_if.sv]
// result channel of the display timing generator
// carries valid, ready and the line, phase, status, interrupt and strobe fields; no dependencies

interface dtg_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] line;
  logic [1:0] phase;
  logic       hblank_flag;
  logic       vblank_flag;
  logic       match_flag;
  logic       hblank_irq;
  logic       vblank_irq;
  logic       match_irq;
  logic       render_strobe;
  logic       dma_hblank_strobe;
  logic       dma_vblank_strobe;

  modport source (
    output valid, input ready,
    output line, output phase, output hblank_flag, output vblank_flag, output match_flag,
    output hblank_irq, output vblank_irq, output match_irq,
    output render_strobe, output dma_hblank_strobe, output dma_vblank_strobe
  );
  modport sink (
    input valid, output ready,
    input line, input phase, input hblank_flag, input vblank_flag, input match_flag,
    input hblank_irq, input vblank_irq, input match_irq,
    input render_strobe, input dma_hblank_strobe, input dma_vblank_strobe
  );
endinterface

[design/dtg_step.sv]
// one timing step: accumulate elapsed cycles, advance at most one phase, update line and flags
// depends on dtg_pkg

module dtg_step (
  input  dtg_pkg::dtg_state_t  state_i,
  input  dtg_pkg::dtg_cfg_t    cfg_i,
  input  logic [7:0]           elapsed_i,
  output dtg_pkg::dtg_state_t  state_o,
  output dtg_pkg::dtg_result_t result_o
);
  import dtg_pkg::*;

  logic [AccW-1:0]  acc_sum;
  logic [AccW-1:0]  phase_len;
  logic [LineW-1:0] line_inc;
  logic [LineW-1:0] new_line;
  logic             line_step;
  logic             h_irq;
  logic             v_irq;
  logic             rend;
  logic             dma_v;
  dtg_state_t       nxt;

  // accumulator wraps at its own width
  assign acc_sum   = state_i.acc + {{(AccW-8){1'b0}}, elapsed_i};
  assign phase_len = state_i.phase[0] ? BLANK_CYCLES : DRAW_CYCLES;
  assign line_inc  = state_i.line + 8'd1;

  always_comb begin
    nxt       = state_i;
    nxt.acc   = acc_sum;
    new_line  = line_inc;
    line_step = 1'b0;
    h_irq     = 1'b0;
    v_irq     = 1'b0;
    rend      = 1'b0;
    dma_v     = 1'b0;
    if (acc_sum >= phase_len) begin
      nxt.acc = acc_sum - phase_len;
      case (state_i.phase)
        PH_DRAW: begin
          nxt.phase  = PH_BLANK;
          nxt.hblank = 1'b1;
          h_irq      = cfg_i.hblank_ie;
          rend       = 1'b1;
        end
        PH_BLANK: begin
          line_step  = 1'b1;
          nxt.hblank = 1'b0;
          nxt.phase  = PH_DRAW;
          if (line_inc == FIRST_VBLANK_LINE) begin
            nxt.phase  = PH_VDRAW;
            nxt.vblank = 1'b1;
            v_irq      = cfg_i.vblank_ie;
            dma_v      = 1'b1;
          end
        end
        PH_VDRAW: begin
          nxt.phase  = PH_VBLANK;
          nxt.hblank = 1'b1;
          h_irq      = cfg_i.hblank_ie;
        end
        PH_VBLANK: begin
          line_step  = 1'b1;
          nxt.hblank = 1'b0;
          nxt.phase  = PH_VDRAW;
          // wrap straight to line zero after the last line
          if (state_i.line >= LAST_LINE) begin
            new_line  = '0;
            nxt.phase = PH_DRAW;
          end else if (line_inc == LAST_LINE) begin
            nxt.vblank = 1'b0;
          end
        end
        default: nxt.phase = PH_DRAW;
      endcase
    end
    if (line_step) begin
      nxt.line  = new_line;
      nxt.match = (new_line == cfg_i.match_line);
    end
  end

  assign state_o = nxt;

  always_comb begin
    result_o.line              = nxt.line;
    result_o.phase             = nxt.phase;
    result_o.hblank_flag       = nxt.hblank;
    result_o.vblank_flag       = nxt.vblank;
    result_o.match_flag        = nxt.match;
    result_o.hblank_irq        = h_irq;
    result_o.vblank_irq        = v_irq;
    result_o.match_irq         = line_step & nxt.match & cfg_i.match_ie;
    result_o.render_strobe     = rend;
    result_o.dma_hblank_strobe = rend;
    result_o.dma_vblank_strobe = dma_v;
  end

endmodule

[design/display_timing_generator_unit.sv]
// display timing generator: one result item per elapsed-cycle item, registered in the output buffer
// throughput one item per cycle while the skid entry is free; the accumulator/phase/line
// update is combinational in the step logic, so the next item may enter on the very next edge
// the result side is a two-entry buffer (output register plus skid), so input ready only
// drops when both entries hold undelivered results
// async active-low reset clears timing state, registers and both valid flags

module display_timing_generator_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  dtg_in_if.sink           in_i,
  dtg_out_if.source        out_o,
  input  logic             cfg_we_i,
  input  dtg_pkg::reg_idx_e cfg_index_i,
  input  logic [7:0]       cfg_data_i
);
  import dtg_pkg::*;

  // configuration registers
  dtg_cfg_t    cfg_q;

  // timing state, updated on every accepted item
  dtg_state_t  state_q;
  dtg_state_t  state_d;
  dtg_result_t result_d;

  // output register and skid entry
  dtg_result_t out_q;
  dtg_result_t skid_q;
  logic        out_valid_q;
  logic        skid_valid_q;

  logic        in_fire;
  logic        out_fire;

  assign in_i.ready = ~skid_valid_q;
  assign in_fire    = in_i.valid & ~skid_valid_q;
  assign out_fire   = out_valid_q & out_o.ready;

  // register writes, bits above a register's width dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_MATCH_LINE: cfg_q.match_line <= cfg_data_i;
        REG_HBLANK_IE:  cfg_q.hblank_ie  <= cfg_data_i[0];
        REG_VBLANK_IE:  cfg_q.vblank_ie  <= cfg_data_i[0];
        REG_MATCH_IE:   cfg_q.match_ie   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  dtg_step u_step (
    .state_i   (state_q),
    .cfg_i     (cfg_q),
    .elapsed_i (in_i.elapsed),
    .state_o   (state_d),
    .result_o  (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{acc: '0, phase: PH_DRAW, line: '0, hblank: 1'b0, vblank: 1'b0,
                   match: 1'b0};
    end else if (in_fire) begin
      state_q <= state_d;
    end
  end

  // result buffer: new items go to the output register when it is free or draining,
  // otherwise they park in the skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (in_fire) begin
      if (out_valid_q && !out_o.ready) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (in_fire) begin
      if (out_valid_q && !out_o.ready) begin
        skid_q <= result_d;
      end else begin
        out_q <= result_d;
      end
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.line              = out_q.line;
  assign out_o.phase             = out_q.phase;
  assign out_o.hblank_flag       = out_q.hblank_flag;
  assign out_o.vblank_flag       = out_q.vblank_flag;
  assign out_o.match_flag        = out_q.match_flag;
  assign out_o.hblank_irq        = out_q.hblank_irq;
  assign out_o.vblank_irq        = out_q.vblank_irq;
  assign out_o.match_irq         = out_q.match_irq;
  assign out_o.render_strobe     = out_q.render_strobe;
  assign out_o.dma_hblank_strobe = out_q.dma_hblank_strobe;
  assign out_o.dma_vblank_strobe = out_q.dma_vblank_strobe;

`ifndef ASSERT_OFF
  // the skid entry is only ever filled behind a held output register
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry valid with empty output register");

  // line counter never leaves the frame
  a_line_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.line <= LAST_LINE)
    else $error("line counter beyond last line");

  // vertical blank status tracks lines 160 to 226
  a_vblank_lines: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.vblank == ((state_q.line >= FIRST_VBLANK_LINE) && (state_q.line < LAST_LINE)))
    else $error("vblank status disagrees with line counter");

  // a render strobe is only shown with the visible blank phase and hblank set
  a_render_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.render_strobe) |-> (out_q.hblank_flag && out_q.phase == PH_BLANK))
    else $error("render strobe outside visible hblank");
`endif

endmodule

[tb/tb.sv]
// self-checking testbench for display_timing_generator_unit
// holds its own line/phase timing predictor and drives the rtl interfaces dtg_in_if and dtg_out_if;
// depends on dtg_pkg and the design files only

module tb;
  import dtg_pkg::*;

  // generous bound: roughly 1250 items at their worst-case handshake gaps, many times over
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned MAX_PRINTED = 40;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  reg_idx_e    cfg_index_i;
  logic [7:0]  cfg_data_i;

  dtg_in_if  in_ch ();
  dtg_out_if res_ch ();

  display_timing_generator_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_ch),
    .out_o       (res_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // predictor copy of the timing state and of the register file
  dtg_state_t  tim_state;
  dtg_cfg_t    tim_cfg;

  // results still owed by the block, oldest first
  dtg_result_t expected_timing_q[$];

  int unsigned cycle_count = 0;
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;

  // when set, that side of the handshake never idles (stretches without gaps)
  bit src_steady = 1'b0;
  bit snk_steady = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always_ff @(posedge clk_i) cycle_count <= cycle_count + 1;

  // run-away guard
  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("FAIL display_timing_generator_unit");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // timing predictor
  // ---------------------------------------------------------------------------

  // draw phases are long, blank phases short
  function automatic logic [AccW-1:0] phase_len();
    if (tim_state.phase == PH_BLANK || tim_state.phase == PH_VBLANK) return BLANK_CYCLES;
    return DRAW_CYCLES;
  endfunction

  // move the counter to a new line, redo the match flag, return the match pulse
  function automatic logic enter_line(input logic [LineW-1:0] n);
    tim_state.line  = n;
    tim_state.match = (n == tim_cfg.match_line);
    return tim_state.match & tim_cfg.match_ie;
  endfunction

  // advance the timing by one elapsed-cycle item; at most one phase change per item
  function automatic dtg_result_t step_timing(input logic [7:0] cycles);
    dtg_result_t     r;
    logic [AccW-1:0] len;
    r = '0;
    tim_state.acc = tim_state.acc + {3'b000, cycles};
    len = phase_len();
    if (tim_state.acc >= len) begin
      tim_state.acc = tim_state.acc - len;
      case (tim_state.phase)
        PH_DRAW: begin
          // visible line finished drawing
          tim_state.phase   = PH_BLANK;
          tim_state.hblank  = 1'b1;
          r.hblank_irq        = tim_cfg.hblank_ie;
          r.render_strobe     = 1'b1;
          r.dma_hblank_strobe = 1'b1;
        end
        PH_BLANK: begin
          r.match_irq      = enter_line(tim_state.line + 8'd1);
          tim_state.hblank = 1'b0;
          tim_state.phase  = PH_DRAW;
          if (tim_state.line == FIRST_VBLANK_LINE) begin
            tim_state.phase     = PH_VDRAW;
            tim_state.vblank    = 1'b1;
            r.vblank_irq        = tim_cfg.vblank_ie;
            r.dma_vblank_strobe = 1'b1;
          end
        end
        PH_VDRAW: begin
          tim_state.hblank = 1'b1;
          r.hblank_irq     = tim_cfg.hblank_ie;
          tim_state.phase  = PH_VBLANK;
        end
        default: begin
          // hblank also drops at each line start inside vertical blank
          tim_state.hblank = 1'b0;
          tim_state.phase  = PH_VDRAW;
          if (tim_state.line == LAST_LINE) begin
            // wrap straight to line 0, no transient line 228
            r.match_irq     = enter_line(8'd0);
            tim_state.phase = PH_DRAW;
          end else begin
            r.match_irq = enter_line(tim_state.line + 8'd1);
            if (tim_state.line == LAST_LINE) tim_state.vblank = 1'b0;
          end
        end
      endcase
    end
    r.line        = tim_state.line;
    r.phase       = tim_state.phase;
    r.hblank_flag = tim_state.hblank;
    r.vblank_flag = tim_state.vblank;
    r.match_flag  = tim_state.match;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // driving and checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_PRINTED) $display("mismatch: %s", msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input int unsigned got, input int unsigned want);
    if (got != want)
      report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                results_seen, name, got, want));
  endtask

  // one elapsed-cycle item; returns at the edge where it is taken
  task automatic send_elapsed(input logic [7:0] cycles);
    int unsigned gap;
    dtg_result_t want;
    gap = src_steady ? 0 : $urandom_range(0, 10);
    @(negedge clk_i);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.elapsed <= cycles;
    do @(posedge clk_i); while (!in_ch.ready);
    want = step_timing(cycles);
    expected_timing_q.push_back(want);
  endtask

  // stop sending and let every owed result arrive, plus a little slack for the pipeline
  task automatic settle_idle();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (expected_timing_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [7:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    // bits above a register's width are dropped
    case (idx)
      REG_MATCH_LINE: tim_cfg.match_line = data;
      REG_HBLANK_IE:  tim_cfg.hblank_ie  = data[0];
      REG_VBLANK_IE:  tim_cfg.vblank_ie  = data[0];
      default:        tim_cfg.match_ie   = data[0];
    endcase
  endtask

  task automatic write_all_regs(input logic [7:0] match_line, input logic [7:0] h_ie,
                                input logic [7:0] v_ie, input logic [7:0] m_ie);
    write_reg(REG_MATCH_LINE, match_line);
    write_reg(REG_HBLANK_IE, h_ie);
    write_reg(REG_VBLANK_IE, v_ie);
    write_reg(REG_MATCH_IE, m_ie);
  endtask

  // mostly large counts so the line counter moves, some exact phase-boundary hits
  function automatic logic [7:0] pick_elapsed();
    int unsigned sel;
    int          room;
    sel = $urandom_range(0, 99);
    if (sel < 5) return 8'd0;
    if (sel < 15) begin
      room = int'(phase_len()) - int'(tim_state.acc) - 1 + int'($urandom_range(0, 2));
      if (room >= 0 && room <= 255) return 8'(room);
      return 8'($urandom_range(192, 255));
    end
    if (sel < 30) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(192, 255));
  endfunction

  // result side: random stalls per item, each accepted item checked against the oldest expectation
  initial begin : result_sink
    int unsigned stall;
    dtg_result_t got;
    dtg_result_t want;
    res_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = snk_steady ? 0 : $urandom_range(0, 10);
      @(negedge clk_i);
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!res_ch.valid);
      got.line              = res_ch.line;
      got.phase             = res_ch.phase;
      got.hblank_flag       = res_ch.hblank_flag;
      got.vblank_flag       = res_ch.vblank_flag;
      got.match_flag        = res_ch.match_flag;
      got.hblank_irq        = res_ch.hblank_irq;
      got.vblank_irq        = res_ch.vblank_irq;
      got.match_irq         = res_ch.match_irq;
      got.render_strobe     = res_ch.render_strobe;
      got.dma_hblank_strobe = res_ch.dma_hblank_strobe;
      got.dma_vblank_strobe = res_ch.dma_vblank_strobe;
      if (expected_timing_q.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
      end else begin
        want = expected_timing_q.pop_front();
        check_field("line", got.line, want.line);
        check_field("phase", got.phase, want.phase);
        check_field("hblank_flag", got.hblank_flag, want.hblank_flag);
        check_field("vblank_flag", got.vblank_flag, want.vblank_flag);
        check_field("match_flag", got.match_flag, want.match_flag);
        check_field("hblank_irq", got.hblank_irq, want.hblank_irq);
        check_field("vblank_irq", got.vblank_irq, want.vblank_irq);
        check_field("match_irq", got.match_irq, want.match_irq);
        check_field("render_strobe", got.render_strobe, want.render_strobe);
        check_field("dma_hblank_strobe", got.dma_hblank_strobe, want.dma_hblank_strobe);
        check_field("dma_vblank_strobe", got.dma_vblank_strobe, want.dma_vblank_strobe);
      end
      results_seen++;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // exact phase boundaries, overshoot, extremes of the count, enables masked by bit 0 only
  task automatic test_directed_edges();
    // one item under the reset register values
    send_elapsed(8'd0);
    settle_idle();
    // upper data bits must not switch the enables on
    write_all_regs(8'd0, 8'hFE, 8'hFE, 8'hFE);
    // reach 960 exactly: hblank entered with its interrupt masked
    send_elapsed(8'd255);
    send_elapsed(8'd255);
    send_elapsed(8'd255);
    send_elapsed(8'd195);
    settle_idle();
    write_all_regs(8'd1, 8'h01, 8'h01, 8'h01);
    // blank length hit exactly, new line 1 matches
    send_elapsed(8'd255);
    send_elapsed(8'd17);
    // one short of the draw length, then the single cycle that crosses it
    send_elapsed(8'd128);
    send_elapsed(8'h55);
    send_elapsed(8'hAA);
    send_elapsed(8'd255);
    send_elapsed(8'd255);
    send_elapsed(8'd66);
    send_elapsed(8'd1);
    // line 2, no match
    send_elapsed(8'd255);
    send_elapsed(8'd16);
    send_elapsed(8'd1);
    // overshoot the draw phase, remainder carried
    send_elapsed(8'd255);
    send_elapsed(8'd255);
    send_elapsed(8'd255);
    send_elapsed(8'd255);
    settle_idle();
  endtask

  // large counts through a whole frame: vblank entry, end of vblank, wrap to line 0
  task automatic test_frame_sweep();
    int unsigned n;
    bit          wrapped;
    logic [7:0]  prev_line;
    // match coincides with vblank entry
    write_all_regs(FIRST_VBLANK_LINE, 8'h01, 8'h01, 8'h01);
    n = 0;
    while (tim_state.line < 8'd200 && n < 3000) begin
      if (n % 64 == 0) begin
        src_steady = ($urandom_range(0, 3) == 0);
        snk_steady = ($urandom_range(0, 3) == 0);
      end
      send_elapsed(8'($urandom_range(232, 255)));
      n++;
    end
    settle_idle();
    // match on the wrap, other interrupts masked
    write_all_regs(8'd0, 8'h00, 8'h00, 8'h01);
    wrapped = 1'b0;
    n = 0;
    while (!(wrapped && tim_state.line >= 8'd3) && n < 3000) begin
      if (n % 64 == 0) begin
        src_steady = ($urandom_range(0, 3) == 0);
        snk_steady = ($urandom_range(0, 3) == 0);
      end
      prev_line = tim_state.line;
      send_elapsed(8'($urandom_range(232, 255)));
      if (prev_line == LAST_LINE && tim_state.line == 8'd0) wrapped = 1'b1;
      n++;
    end
    settle_idle();
  endtask

  // several register settings, extremes first, each with a run of random counts
  task automatic test_random_configs();
    logic [7:0] match_line;
    logic [7:0] h_ie;
    logic [7:0] v_ie;
    logic [7:0] m_ie;
    for (int k = 0; k < 6; k++) begin
      case (k)
        0: match_line = 8'd0;
        1: match_line = 8'd255;  // beyond the last line, never matches
        2: match_line = 8'd228;
        3: match_line = LAST_LINE;
        default: match_line = 8'($urandom_range(0, 255));
      endcase
      h_ie = 8'($urandom_range(0, 255));
      v_ie = 8'($urandom_range(0, 255));
      m_ie = 8'($urandom_range(0, 255));
      if (k == 0) begin
        h_ie = 8'hFF;
        v_ie = 8'hFF;
        m_ie = 8'hFF;
      end else if (k == 1) begin
        h_ie = 8'h00;
        v_ie = 8'h00;
        m_ie = 8'h00;
      end
      settle_idle();
      write_all_regs(match_line, h_ie, v_ie, m_ie);
      for (int i = 0; i < 10; i++) begin
        if (i % 5 == 0) begin
          src_steady = ($urandom_range(0, 3) == 0);
          snk_steady = ($urandom_range(0, 3) == 0);
        end
        send_elapsed(pick_elapsed());
      end
    end
    settle_idle();
  endtask

  initial begin : stimulus
    in_ch.valid   = 1'b0;
    in_ch.elapsed = 8'd0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = REG_MATCH_LINE;
    cfg_data_i    = 8'd0;
    rst_ni        = 1'b0;
    tim_state     = '0;
    tim_cfg       = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_edges();
    test_frame_sweep();
    test_random_configs();

    settle_idle();
    if (mismatches == 0) begin
      $display("PASS display_timing_generator_unit");
    end else begin
      $display("FAIL display_timing_generator_unit");
    end
    $finish;
  end

endmodule

[sim.f]
design/dtg_pkg.sv
design/dtg_in_if.sv
design/dtg_out_if.sv
design/dtg_step.sv
design/display_timing_generator_unit.sv
tb/tb.sv
